// ===== sv/phit_pkg.sv =====
// shared types and constants of the probed hash index table
// used by phit_ctrl and probed_hash_index_table_unit; no dependencies

package phit_pkg;

    // default table size and fixed field widths
    localparam int DEF_TABLE_SLOTS = 2048;
    localparam int MODE_W          = 2;
    localparam int SLOT_W          = 11;
    localparam int CHECK_W         = 32;
    localparam int BLOCK_W         = 11;
    localparam int STATUS_W        = 2;

    // operation codes (code 3 behaves as a lookup)
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // slot states kept in memory
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    // one request as taken from the input stream
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SLOT_W-1:0]  home_slot;
        logic [CHECK_W-1:0] check_a;
        logic [CHECK_W-1:0] check_b;
        logic [BLOCK_W-1:0] block_number;
    } t_req;

    // one result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [BLOCK_W-1:0]  found_block;
    } t_res;

    // one table slot as stored in memory
    typedef struct packed {
        logic [1:0]         st;
        logic [CHECK_W-1:0] check_a;
        logic [CHECK_W-1:0] check_b;
        logic [BLOCK_W-1:0] block;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

// ===== sv/phit_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module phit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_data;

endmodule

// ===== sv/phit_ctrl.sv =====
// probe controller: clearing pass, linear probe over the slot ram, write-back
// depends on phit_pkg; drives the ports of one phit_ram

module phit_ctrl #(
    parameter int TABLE_SLOTS = phit_pkg::DEF_TABLE_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           i_req_valid,
    input  phit_pkg::t_req                 i_req,
    output logic                           o_req_ready,
    // result side
    output logic                           o_res_valid,
    output phit_pkg::t_res                 o_res,
    input  logic                           i_res_ready,
    // slot ram
    output logic [$clog2(TABLE_SLOTS)-1:0] o_rd_addr,
    input  logic [phit_pkg::ENTRY_W-1:0]   i_rd_data,
    output logic                           o_wr_en,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_wr_addr,
    output logic [phit_pkg::ENTRY_W-1:0]   o_wr_data
);

    localparam int SW = $clog2(TABLE_SLOTS);

    phit_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_clr;
    phit_pkg::t_req   r_req;
    logic [SW-1:0]    r_issue;
    logic [SW-1:0]    r_chk;
    logic             r_pend;
    logic [SW:0]      r_seen;
    logic             r_free_vld;
    logic [SW-1:0]    r_free;
    phit_pkg::t_res   r_res;

    phit_pkg::t_entry w_ent;
    phit_pkg::t_res   w_res;
    logic [SW-1:0]    w_home;
    logic [phit_pkg::SLOT_W-1:0] w_h;
    logic             w_empty;
    logic             w_deleted;
    logic             w_match;
    logic             w_last;
    logic             w_fin;
    logic             w_wr;
    logic [SW-1:0]    w_wr_slot;
    phit_pkg::t_entry w_wr_ent;

    // home slot modulo table size by conditional subtraction of shifted sizes
    always_comb begin
        w_h = i_req.home_slot;
        for (int k = 6; k >= 0; k--) begin
            if (int'(w_h) >= (TABLE_SLOTS << k)) begin
                w_h = w_h - phit_pkg::SLOT_W'(TABLE_SLOTS << k);
            end
        end
        w_home = SW'(w_h);
    end

    // classify the slot whose data arrives this cycle
    assign w_ent     = phit_pkg::t_entry'(i_rd_data);
    assign w_empty   = (w_ent.st == phit_pkg::SLOT_EMPTY);
    assign w_deleted = (w_ent.st == phit_pkg::SLOT_DELETED);
    assign w_match   = (w_ent.st == phit_pkg::SLOT_USED) && (w_ent.check_a == r_req.check_a)
                       && (w_ent.check_b == r_req.check_b);
    assign w_last    = (r_seen == (SW+1)'(TABLE_SLOTS - 1));
    assign w_fin     = (r_state == phit_pkg::S_PROBE) && r_pend
                       && (w_empty || w_match || w_last);

    // result and write-back decision at the end of a probe run
    always_comb begin
        w_res       = '0;
        w_res.status = phit_pkg::ST_NOT_FOUND;
        w_wr        = 1'b0;
        w_wr_slot   = r_chk;
        w_wr_ent    = w_ent;
        case (r_req.mode)
            phit_pkg::MODE_INSERT: begin
                if (w_match) begin
                    w_res.status = phit_pkg::ST_PRESENT;
                end else if (r_free_vld || w_empty || w_deleted) begin
                    w_wr              = 1'b1;
                    w_wr_slot         = r_free_vld ? r_free : r_chk;
                    w_wr_ent.st       = phit_pkg::SLOT_USED;
                    w_wr_ent.check_a  = r_req.check_a;
                    w_wr_ent.check_b  = r_req.check_b;
                    w_wr_ent.block    = r_req.block_number;
                    w_res.status      = phit_pkg::ST_OK;
                    w_res.slot        = phit_pkg::SLOT_W'(w_wr_slot);
                end else begin
                    w_res.status = phit_pkg::ST_FULL;
                end
            end
            phit_pkg::MODE_REMOVE: begin
                if (w_match) begin
                    w_wr              = 1'b1;
                    w_wr_ent.st       = phit_pkg::SLOT_DELETED;
                    w_res.status      = phit_pkg::ST_OK;
                    w_res.slot        = phit_pkg::SLOT_W'(r_chk);
                    w_res.found_block = w_ent.block;
                end
            end
            default: begin
                if (w_match) begin
                    w_res.status      = phit_pkg::ST_OK;
                    w_res.slot        = phit_pkg::SLOT_W'(r_chk);
                    w_res.found_block = w_ent.block;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            phit_pkg::S_CLEAR: begin
                if (r_clr == SW'(TABLE_SLOTS - 1)) n_state = phit_pkg::S_IDLE;
            end
            phit_pkg::S_IDLE: begin
                if (i_req_valid) n_state = phit_pkg::S_PROBE;
            end
            phit_pkg::S_PROBE: begin
                if (w_fin) n_state = phit_pkg::S_DONE;
            end
            phit_pkg::S_DONE: begin
                if (i_res_ready) n_state = phit_pkg::S_IDLE;
            end
            default: n_state = phit_pkg::S_CLEAR;
        endcase
    end

    // outputs and ram port control
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_clr;
        o_wr_data   = '0;
        case (r_state)
            phit_pkg::S_CLEAR: begin
                o_wr_en = 1'b1;
            end
            phit_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
            end
            phit_pkg::S_PROBE: begin
                o_wr_en   = w_fin && w_wr;
                o_wr_addr = w_wr_slot;
                o_wr_data = w_wr_ent;
            end
            phit_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = r_issue;
    assign o_res     = r_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phit_pkg::S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == phit_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == phit_pkg::S_PROBE) begin
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // probe datapath: one read issued per cycle, its data evaluated in the cycle after
    always_ff @(posedge i_clk) begin
        if (r_state == phit_pkg::S_IDLE && i_req_valid) begin
            r_req      <= i_req;
            r_issue    <= w_home;
            r_seen     <= '0;
            r_free_vld <= 1'b0;
        end else if (r_state == phit_pkg::S_PROBE) begin
            r_issue <= (r_issue == SW'(TABLE_SLOTS - 1)) ? '0 : r_issue + 1'b1;
            r_chk   <= r_issue;
            if (r_pend && !w_fin) begin
                r_seen <= r_seen + 1'b1;
                if (w_deleted && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free     <= r_chk;
                end
            end
            if (w_fin) begin
                r_res <= w_res;
            end
        end
    end

endmodule

// ===== sv/probed_hash_index_table_unit.sv =====
// top level of the probed hash index table: stream ports, output register
// depends on phit_pkg, phit_ram and phit_ctrl
//
// channel   direction  signals                          content
// s_axis    in         tvalid tready tdata[87:0] tuser  one table request
// m_axis    out        tvalid tready tdata[23:0]        one result per request
//
// an item visits k slots (1 <= k <= TABLE_SLOTS); the probe loop reads one slot of
// the single slot ram per cycle, through its registered read port.
// after reset a clearing pass empties every slot; no request is taken during
// it. a finished result waits in the output register and the next request is
// taken meanwhile; the controller holds its result while that register is still
// full.

module probed_hash_index_table_unit #(
    parameter int TABLE_SLOTS = phit_pkg::DEF_TABLE_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // home_slot[10:0], check_a[42:11], check_b[74:43], block_number[85:75], zero pad
    input  logic [87:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[1:0], slot[12:2], found_block[23:13]
    output logic [23:0] o_m_axis_tdata
);

    localparam int SW = $clog2(TABLE_SLOTS);

    phit_pkg::t_req req;
    phit_pkg::t_res res;
    logic           res_valid;
    logic           res_ready;
    logic [SW-1:0]  rd_addr;
    logic [phit_pkg::ENTRY_W-1:0] rd_data;
    logic           wr_en;
    logic [SW-1:0]  wr_addr;
    logic [phit_pkg::ENTRY_W-1:0] wr_data;

    logic           r_m_valid;
    phit_pkg::t_res r_m_res;

    // unpack the request transfer
    assign req.mode         = i_s_axis_tuser;
    assign req.home_slot    = i_s_axis_tdata[10:0];
    assign req.check_a      = i_s_axis_tdata[42:11];
    assign req.check_b      = i_s_axis_tdata[74:43];
    assign req.block_number = i_s_axis_tdata[85:75];

    // slot storage: status, check words and block index per slot
    phit_ram #(
        .WIDTH (phit_pkg::ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    phit_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (o_s_axis_tready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // output register
    assign res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_res.found_block, r_m_res.slot, r_m_res.status};

    // a failed operation never reports a slot or a block
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_res.status != phit_pkg::ST_OK)
            |-> (r_m_res.slot == '0 && r_m_res.found_block == '0))
        else $error("failed result carries slot or block");

    // the slot ram is only written while no request can be taken
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !o_s_axis_tready)
        else $error("slot write while accepting requests");

    // one request in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second request taken during a probe");

endmodule
